// ===== src/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants for the sketch range filter
// Holds the line store geometry, pixel constants, the stage struct and the
// small min/max helpers used by the window datapath.
// ----------------------------------------------------------------------------
package srf_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Line width register
  localparam int WIDTH_W          = 12;
  localparam int EW_W             = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int LINE_WIDTH_RESET = 640;

  // Pixel format
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;

  // Row counter saturates at the first fully filtered row
  localparam int ROW_W   = 2;
  localparam int ROW_MAX = 2;
  localparam int COL_MIN = 2;

  // Output queue and in-flight limit
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Item moving from the read stage into the window stage
  typedef struct packed {
    logic             valid;
    logic             filt;
    logic             fwd;
    logic [PIX_W-1:0] pix;
  } srf_stage_t;

  function automatic logic [PIX_W-1:0] pix_min(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    pix_min = (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] pix_max(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    pix_max = (a > b) ? a : b;
  endfunction

endpackage

// ===== src/srf_line_ram.sv =====
// ----------------------------------------------------------------------------
// srf_line_ram: simple dual-port line store
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module srf_line_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/srf_window.sv =====
// ----------------------------------------------------------------------------
// srf_window: window stage and range computation
// Resolves the line store read (with forwarding from the previous write),
// writes the rows back, shifts the 3x3 window and computes the clamped
// 255 - 2*(max - min) result one stage later.
// ----------------------------------------------------------------------------
module srf_window
  import srf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  srf_stage_t       stage,
  input  logic [PIX_W-1:0] rd_older,
  input  logic [PIX_W-1:0] rd_prev,
  output logic             wr_en,
  output logic [PIX_W-1:0] wr_older,
  output logic [PIX_W-1:0] wr_prev,
  output logic             res_valid,
  output logic [PIX_W-1:0] res_pixel
);

  logic [PIX_W-1:0] last_older;
  logic [PIX_W-1:0] last_prev;
  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] cur_older;
  logic [PIX_W-1:0] cur_prev;
  logic [PIX_W-1:0] taps [9];
  logic [PIX_W-1:0] hi_next;
  logic [PIX_W-1:0] lo_next;

  logic             s2_valid;
  logic             s2_filt;
  logic [PIX_W-1:0] s2_pix;
  logic [PIX_W-1:0] s2_hi;
  logic [PIX_W-1:0] s2_lo;
  logic [PIX_W-1:0] diff;
  logic [PIX_W:0]   dbl;

  // Take the last written rows when the read raced the write
  assign cur_older = stage.fwd ? last_older : rd_older;
  assign cur_prev  = stage.fwd ? last_prev  : rd_prev;

  // Shift the column above down one row, store the new pixel
  assign wr_en    = stage.valid;
  assign wr_older = cur_prev;
  assign wr_prev  = stage.pix;

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      last_older <= cur_prev;
      last_prev  <= stage.pix;
    end
  end

  // Advance the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (stage.valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k] <= win[k+3];
      end
      win[3] <= cur_older;
      win[4] <= cur_prev;
      win[5] <= stage.pix;
    end
  end

  // Max and min over the nine window pixels
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      taps[k] = win[k];
    end
    taps[6] = cur_older;
    taps[7] = cur_prev;
    taps[8] = stage.pix;
    hi_next = taps[0];
    lo_next = taps[0];
    for (int k = 1; k < 9; k++) begin
      hi_next = pix_max(hi_next, taps[k]);
      lo_next = pix_min(lo_next, taps[k]);
    end
  end

  // Hold the range for the clamp stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      s2_filt <= stage.filt;
      s2_pix  <= stage.pix;
      s2_hi   <= hi_next;
      s2_lo   <= lo_next;
    end
  end

  // Clamp 255 - 2*(max - min) at zero, pass border pixels through
  assign diff = s2_hi - s2_lo;
  assign dbl  = {diff, 1'b0};

  always_comb begin
    if (!s2_filt) begin
      res_pixel = s2_pix;
    end else if (dbl >= (PIX_W+1)'(PIX_MAX)) begin
      res_pixel = '0;
    end else begin
      res_pixel = PIX_W'(PIX_MAX) - dbl[PIX_W-1:0];
    end
  end

  assign res_valid = s2_valid;

endmodule

// ===== src/srf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// srf_out_fifo: output queue
// Small queue that decouples the fixed-latency datapath from the output
// stall; the in-flight limit at the input keeps it from overflowing.
// ----------------------------------------------------------------------------
module srf_out_fifo
  import srf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [PIX_W-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [PIX_W-1:0] head_data
);

  logic [PIX_W-1:0] slot [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign not_empty = (fill != '0);
  assign head_data = slot[rd_ptr];

endmodule

// ===== src/sketch_range_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// sketch_range_filter_3x3: 3x3 range (max - min) sketch filter
// Grayscale pixels in raster order; one filtered pixel per input pixel.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with gray_pixel and frame_start; the
// flagged pixel restarts at column 0, row 0. Output channel: out_valid /
// out_stall with sketch_pixel, one item per input item, in order.
// Configuration: cfg_valid / cfg_ready with line_width (pixels per row,
// reset 640); cfg_ready is always high, write it only while idle.
// Throughput: one item per cycle while in_stall is low. From input accept to
// out_valid an item passes the line store read, the window min/max and the
// clamp into the output queue. The registered line store read feeds its write
// in the next cycle; back-to-back accesses to the same column are forwarded.
// At most four items are in flight; when out_stall holds the queue full,
// in_stall rises until items drain. Reset clears the counters, the window and
// the queue; the line stores are not cleared and are filled by the first two
// rows of a frame, which pass through unchanged (as do the first two columns).
// ----------------------------------------------------------------------------
module sketch_range_filter_3x3
  import srf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   gray_pixel,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   sketch_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIDTH_W-1:0] line_width
);

  logic [WIDTH_W-1:0] width_reg;
  logic [EW_W-1:0]    eff_width;
  logic [COL_W-1:0]   column_count;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic               row_last;
  logic               accept;
  logic               pop;
  logic [CNT_W-1:0]   inflight;
  srf_stage_t         s1;
  logic [COL_W-1:0]   s1_addr;
  logic [2*PIX_W-1:0] rd_data;
  logic               wr_en;
  logic [PIX_W-1:0]   wr_older;
  logic [PIX_W-1:0]   wr_prev;
  logic               res_valid;
  logic [PIX_W-1:0]   res_pixel;

  // Line width register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_W'(LINE_WIDTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      width_reg <= line_width;
    end
  end

  // Clamp the width into 1..MAX_WIDTH
  always_comb begin
    if (width_reg == '0) begin
      eff_width = EW_W'(1);
    end else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH)) begin
      eff_width = EW_W'(MAX_WIDTH);
    end else begin
      eff_width = EW_W'(width_reg);
    end
  end

  // Handshake and in-flight limit
  assign in_stall = (inflight == CNT_W'(OUT_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({accept, pop})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  // Position of the incoming pixel
  assign col_cur  = frame_start ? '0 : column_count;
  assign row_cur  = frame_start ? '0 : row_count;
  assign row_last = (EW_W'(col_cur) >= eff_width - EW_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_last) begin
        column_count <= '0;
        row_count    <= (row_cur < ROW_W'(ROW_MAX)) ? row_cur + 1'b1 : row_cur;
      end else begin
        column_count <= col_cur + 1'b1;
        row_count    <= row_cur;
      end
    end
  end

  // Read stage register; flag a read that races the write of the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
    end
    if (accept) begin
      s1.filt <= (row_cur == ROW_W'(ROW_MAX)) && (col_cur >= COL_W'(COL_MIN));
      s1.fwd  <= s1.valid && (s1_addr == col_cur);
      s1.pix  <= gray_pixel;
      s1_addr <= col_cur;
    end
  end

  // Two rows above, packed as {row y-2, row y-1}
  srf_line_ram #(
    .DATA_W (2 * PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data ({wr_older, wr_prev}),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_data)
  );

  srf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .stage     (s1),
    .rd_older  (rd_data[2*PIX_W-1:PIX_W]),
    .rd_prev   (rd_data[PIX_W-1:0]),
    .wr_en     (wr_en),
    .wr_older  (wr_older),
    .wr_prev   (wr_prev),
    .res_valid (res_valid),
    .res_pixel (res_pixel)
  );

  srf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_pixel),
    .pop       (pop),
    .not_empty (out_valid),
    .head_data (sketch_pixel)
  );

endmodule
